>>> rtl/core/ajb_pkg.sv
// ajb_pkg: shared types and constants of the audio jitter buffer.
// Used by the interfaces' users, the front end, the playout engine and the top level.
package ajb_pkg;

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_TICK  = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_RSVD  = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_STORED    = 4'd0,
      ST_REJECTED  = 4'd1,
      ST_LATE      = 4'd2,
      ST_PLAY      = 4'd3,
      ST_CONCEAL   = 4'd4,
      ST_SKIPPED   = 4'd5,
      ST_REANCHOR  = 4'd6,
      ST_NOT_READY = 4'd7,
      ST_FLUSHED   = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      CSR_ATTACHED = 2'd0,
      CSR_BUFFER   = 2'd1,
      CSR_EQ       = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_PUSH,
      CMD_BAD_PUSH,
      CMD_TICK,
      CMD_FLUSH,
      CMD_INVALID
   } cmd_type;

   typedef struct packed {
      cmd_type      cmd;
      logic [31:0]  seq;
      logic [47:0]  pts;
      logic [31:0]  payload_ref;
      logic [11:0]  payload_len;
      logic         frame_late;
   } cmd_item_type;

   typedef struct packed {
      logic         attached;
      logic [10:0]  delay_ms;
      logic [9:0]   eq_ms;
   } cfg_type;

   localparam int CSR_WIDTH = 11;
   localparam logic [10:0] DELAY_MS_RESET = 11'd100;
   localparam logic [19:0] NS_PER_MS = 20'd1000000;

endpackage

>>> rtl/core/ajb_if.sv
// ajb_if: valid/ready channel interfaces of the audio jitter buffer.
// ajb_req_if carries request words, ajb_rsp_if carries result words; no dependencies.
interface ajb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] seq;
   logic [47:0] pts;
   logic [31:0] payload_ref;
   logic [11:0] payload_len;
   logic        frame_late;

   modport source (output valid, req_type, seq, pts, payload_ref, payload_len, frame_late,
                   input ready);
   modport sink   (input valid, req_type, seq, pts, payload_ref, payload_len, frame_late,
                   output ready);
endinterface

interface ajb_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [31:0] out_seq;
   logic [47:0] due_time;
   logic [31:0] out_ref;
   logic [11:0] out_len;
   logic [5:0]  buffered;
   logic [31:0] played_count;
   logic [31:0] silence_count;
   logic [31:0] late_count;

   modport source (output valid, status, out_seq, due_time, out_ref, out_len, buffered,
                   played_count, silence_count, late_count, input ready);
   modport sink   (input valid, status, out_seq, due_time, out_ref, out_len, buffered,
                   played_count, silence_count, late_count, output ready);
endinterface

>>> rtl/core/ajb_front.sv
// ajb_front: accepts request words, classifies them and queues them (two entries).
// Depends on ajb_pkg and ajb_req_if.
module ajb_front #(
   parameter int MAX_PAYLOAD = 3840
) (
   input  logic                  clock,
   input  logic                  reset,
   ajb_req_if.sink               req_chan,
   output ajb_pkg::cmd_item_type cmd_item,
   output logic                  cmd_valid,
   input  logic                  cmd_pop
);
   import ajb_pkg::*;

   cmd_item_type q_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   cmd_item_type cls;
   logic         push;

   always_comb begin
      cls.seq         = req_chan.seq;
      cls.pts         = req_chan.pts;
      cls.payload_ref = req_chan.payload_ref;
      cls.payload_len = req_chan.payload_len;
      cls.frame_late  = req_chan.frame_late;
      case (req_kind_type'(req_chan.req_type))
         REQ_PUSH: begin
            if (req_chan.payload_len == 12'd0 || req_chan.payload_len > 12'(MAX_PAYLOAD))
               cls.cmd = CMD_BAD_PUSH;
            else
               cls.cmd = CMD_PUSH;
         end
         REQ_TICK:  cls.cmd = CMD_TICK;
         REQ_FLUSH: cls.cmd = CMD_FLUSH;
         default:   cls.cmd = CMD_INVALID;
      endcase
   end

   assign req_chan.ready = (cnt_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (cnt_ff != 2'd0);
   assign cmd_item       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (cmd_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(cmd_pop);
      end
   end

endmodule

>>> rtl/core/ajb_engine.sv
// ajb_engine: slot store, sequential slot scan, playout arithmetic and result register.
// Depends on ajb_pkg and ajb_rsp_if.
module ajb_engine #(
   parameter int NUM_SLOTS     = 32,
   parameter int REANCHOR_GAPS = 25,
   parameter int FRAME_NS      = 20000000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ajb_pkg::cfg_type      cfg,
   input  ajb_pkg::cmd_item_type cmd_item,
   input  logic                  cmd_valid,
   output logic                  cmd_pop,
   ajb_rsp_if.source             rsp_chan
);
   import ajb_pkg::*;

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam logic [26:0] FRAME_C = 27'(FRAME_NS);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_STORE, S_FETCH, S_TICK, S_DONE} state_type;

   state_type      state_ff;
   cmd_item_type   cur_ff;
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [CW-1:0]  cnt_ff;
   logic           anchored_ff;
   logic [31:0]    next_seq_ff, origin_seq_ff;
   logic [47:0]    origin_time_ff;
   logic [4:0]     gap_ff;
   logic [31:0]    played_ff, silence_ff, late_ff;

   logic [IW-1:0]  addr_ff, pidx_ff, k_ff, vic_ff;
   logic [31:0]    vic_seq_ff;
   logic           issue_ff, pend_ff, found_ff;
   logic [47:0]    prod_a_ff;
   logic [31:0]    prod_b_ff;

   status_type     status_ff;
   logic [31:0]    oseq_ff, oref_ff;
   logic [47:0]    due_ff;
   logic [11:0]    olen_ff;

   logic [31:0]    seq_mem [NUM_SLOTS];
   logic [31:0]    ref_mem [NUM_SLOTS];
   logic [11:0]    len_mem [NUM_SLOTS];
   logic [31:0]    rd_seq_q, rd_ref_q;
   logic [11:0]    rd_len_q;

   logic [31:0]    seq_diff;
   logic [58:0]    prod_a_full;
   logic [31:0]    prod_b_full;
   logic [11:0]    ms_sum;
   logic [4:0]     gap_inc;
   logic           slot_last, out_free;

   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
   assign ms_sum    = 12'(cfg.delay_ms) + 12'(cfg.eq_ms);
   assign slot_last = (pidx_ff == IW'(NUM_SLOTS - 1));
   assign gap_inc   = gap_ff + 5'd1;
   assign out_free  = !rsp_chan.valid || rsp_chan.ready;

   // frame offset wraps at 32 bits before scaling
   assign seq_diff  = next_seq_ff - origin_seq_ff;

   always_comb begin
      prod_a_full = seq_diff * FRAME_C;
      prod_b_full = ms_sum * NS_PER_MS;
   end

   // slot memories: one write port, registered reads
   always_ff @(posedge clock) begin
      if (state_ff == S_STORE) begin
         seq_mem[k_ff] <= cur_ff.seq;
         ref_mem[k_ff] <= cur_ff.payload_ref;
         len_mem[k_ff] <= cur_ff.payload_len;
      end
      rd_seq_q <= seq_mem[addr_ff];
      rd_ref_q <= ref_mem[k_ff];
      rd_len_q <= len_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         valid_ff       <= '0;
         cnt_ff         <= '0;
         anchored_ff    <= 1'b0;
         next_seq_ff    <= '0;
         origin_seq_ff  <= '0;
         origin_time_ff <= '0;
         gap_ff         <= '0;
         played_ff      <= '0;
         silence_ff     <= '0;
         late_ff        <= '0;
         issue_ff       <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_chan.valid <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready && state_ff != S_DONE)
            rsp_chan.valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cur_ff    <= cmd_item;
                  oseq_ff   <= '0;
                  due_ff    <= '0;
                  oref_ff   <= '0;
                  olen_ff   <= '0;
                  status_ff <= ST_REJECTED;
                  addr_ff   <= '0;
                  issue_ff  <= 1'b1;
                  pend_ff   <= 1'b0;
                  found_ff  <= 1'b0;
                  state_ff  <= S_DONE;
                  case (cmd_item.cmd)
                     CMD_PUSH: begin
                        if (cfg.attached) begin
                           if (!anchored_ff) begin
                              anchored_ff    <= 1'b1;
                              next_seq_ff    <= cmd_item.seq;
                              origin_seq_ff  <= cmd_item.seq;
                              origin_time_ff <= cmd_item.pts;
                              state_ff       <= S_SCAN;
                           end else if (cmd_item.seq < next_seq_ff) begin
                              late_ff   <= late_ff + 32'd1;
                              status_ff <= ST_LATE;
                           end else begin
                              state_ff <= S_SCAN;
                           end
                        end
                     end
                     CMD_TICK: begin
                        if (!cfg.attached || !anchored_ff) begin
                           status_ff <= ST_NOT_READY;
                        end else begin
                           prod_a_ff <= prod_a_full[47:0];
                           prod_b_ff <= prod_b_full;
                           state_ff  <= S_SCAN;
                        end
                     end
                     CMD_FLUSH: begin
                        valid_ff    <= '0;
                        cnt_ff      <= '0;
                        anchored_ff <= 1'b0;
                        status_ff   <= ST_FLUSHED;
                     end
                     default: status_ff <= ST_REJECTED;
                  endcase
               end
            end
            S_SCAN: begin
               // issue one read per cycle, evaluate the previous one
               if (issue_ff) begin
                  pend_ff <= 1'b1;
                  pidx_ff <= addr_ff;
                  if (addr_ff == IW'(NUM_SLOTS - 1)) issue_ff <= 1'b0;
                  else addr_ff <= addr_ff + IW'(1);
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff) begin
                  if (cur_ff.cmd == CMD_PUSH) begin
                     if (!valid_ff[pidx_ff] || rd_seq_q < next_seq_ff) begin
                        k_ff     <= pidx_ff;
                        state_ff <= S_STORE;
                     end else begin
                        if (pidx_ff == '0 || rd_seq_q < vic_seq_ff) begin
                           vic_ff     <= pidx_ff;
                           vic_seq_ff <= rd_seq_q;
                        end
                        if (slot_last) begin
                           if (rd_seq_q < vic_seq_ff) k_ff <= pidx_ff;
                           else k_ff <= vic_ff;
                           state_ff <= S_STORE;
                        end
                     end
                  end else begin
                     if (valid_ff[pidx_ff] && rd_seq_q == next_seq_ff) begin
                        k_ff     <= pidx_ff;
                        found_ff <= 1'b1;
                        state_ff <= S_FETCH;
                     end else if (slot_last) begin
                        state_ff <= S_TICK;
                     end
                  end
               end
            end
            S_STORE: begin
               if (!valid_ff[k_ff]) cnt_ff <= cnt_ff + CW'(1);
               valid_ff[k_ff] <= 1'b1;
               status_ff      <= ST_STORED;
               state_ff       <= S_DONE;
            end
            S_FETCH: state_ff <= S_TICK;
            S_TICK: begin
               oseq_ff     <= next_seq_ff;
               due_ff      <= origin_time_ff + prod_a_ff + 48'(prod_b_ff);
               next_seq_ff <= next_seq_ff + 32'd1;
               if (cur_ff.frame_late) begin
                  if (found_ff) begin
                     valid_ff[k_ff] <= 1'b0;
                     cnt_ff         <= cnt_ff - CW'(1);
                     late_ff        <= late_ff + 32'd1;
                  end
                  status_ff <= ST_SKIPPED;
               end else if (found_ff) begin
                  valid_ff[k_ff] <= 1'b0;
                  cnt_ff         <= cnt_ff - CW'(1);
                  oref_ff        <= rd_ref_q;
                  olen_ff        <= rd_len_q;
                  played_ff      <= played_ff + 32'd1;
                  gap_ff         <= '0;
                  status_ff      <= ST_PLAY;
               end else begin
                  silence_ff <= silence_ff + 32'd1;
                  if (gap_inc >= 5'(REANCHOR_GAPS)) begin
                     anchored_ff <= 1'b0;
                     gap_ff      <= '0;
                     status_ff   <= ST_REANCHOR;
                  end else begin
                     gap_ff    <= gap_inc;
                     status_ff <= ST_CONCEAL;
                  end
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_chan.valid <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result payload: loaded with the word
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_chan.status        <= status_ff;
         rsp_chan.out_seq       <= oseq_ff;
         rsp_chan.due_time      <= due_ff;
         rsp_chan.out_ref       <= oref_ff;
         rsp_chan.out_len       <= olen_ff;
         rsp_chan.buffered      <= 6'(cnt_ff);
         rsp_chan.played_count  <= played_ff;
         rsp_chan.silence_count <= silence_ff;
         rsp_chan.late_count    <= late_ff;
      end
   end

endmodule

>>> rtl/core/audio_jitter_buffer.sv
// audio_jitter_buffer: top level of the sequence-numbered jitter buffer.
// Depends on ajb_pkg, ajb_if, ajb_front and ajb_engine.
//
// Usage:
//   req_chan carries request words: push a frame descriptor, playout tick, or flush.
//   rsp_chan returns exactly one result word per request word, in order.
//   csr_we/csr_index/csr_wdata write stream_attached, the buffering delay and the
//   equalization delay; write them only while no request is outstanding.
// Flow:
//   A request word sits in a two-entry queue, then the engine scans the slot store
//   one slot per cycle through its registered-read memory. Only pushes and ticks
//   scan; flush, reject, late drop and not-ready words skip the scan. The engine
//   takes a new word only once the result of the last one is in the output register.
// Reset:
//   Synchronous, active high. Clears slot valid bits, the anchor, counters and
//   the queue; the buffering delay returns to 100 ms, the equalization delay to 0,
//   the stream is detached. No clearing pass is needed.
// Stall:
//   A finished word waits in the output register while the queue keeps taking
//   new words; the queue drops ready when both entries are full.
module audio_jitter_buffer #(
   parameter int NUM_SLOTS     = 32,
   parameter int REANCHOR_GAPS = 25,
   parameter int FRAME_NS      = 20000000,
   parameter int MAX_PAYLOAD   = 3840
) (
   input  logic        clock,
   input  logic        reset,
   ajb_req_if.sink     req_chan,
   ajb_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   import ajb_pkg::*;

   cfg_type      cfg_ff;
   cmd_item_type cmd_item;
   logic         cmd_valid;
   logic         cmd_pop;

   // configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attached <= 1'b0;
         cfg_ff.delay_ms <= DELAY_MS_RESET;
         cfg_ff.eq_ms    <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ATTACHED: cfg_ff.attached <= csr_wdata[0];
            CSR_BUFFER:   cfg_ff.delay_ms <= csr_wdata;
            CSR_EQ:       cfg_ff.eq_ms    <= csr_wdata[9:0];
            default:      cfg_ff          <= cfg_ff;
         endcase
      end
   end

   // front: accept and classify, hold up to two words
   ajb_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cmd_item (cmd_item),
      .cmd_valid(cmd_valid),
      .cmd_pop  (cmd_pop)
   );

   // back: slot scan, playout arithmetic, result register
   ajb_engine #(
      .NUM_SLOTS    (NUM_SLOTS),
      .REANCHOR_GAPS(REANCHOR_GAPS),
      .FRAME_NS     (FRAME_NS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd_item (cmd_item),
      .cmd_valid(cmd_valid),
      .cmd_pop  (cmd_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/core/ajb_checker.sv
// ajb_checker: port-level assertions for audio_jitter_buffer, attached by bind.
// Depends on ajb_pkg.
module ajb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  status,
   input logic [31:0] out_seq,
   input logic [47:0] due_time,
   input logic [11:0] out_len,
   input logic [31:0] out_ref
);
   import ajb_pkg::*;

   // hold a stalled word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(due_time))
      else $error("stalled word changed");

   // no word straight out of reset
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("word after reset");

   // a played frame always has a nonzero length
   a_play_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_PLAY |-> out_len != 12'd0)
      else $error("played frame with zero length");

   // non-tick words carry no sequence, time or descriptor
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_STORED || status == ST_REJECTED || status == ST_LATE ||
                    status == ST_NOT_READY || status == ST_FLUSHED)
      |-> out_seq == 32'd0 && due_time == 48'd0 && out_ref == 32'd0)
      else $error("non-tick word with tick fields");

endmodule

bind audio_jitter_buffer ajb_checker u_ajb_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .status   (rsp_chan.status),
   .out_seq  (rsp_chan.out_seq),
   .due_time (rsp_chan.due_time),
   .out_len  (rsp_chan.out_len),
   .out_ref  (rsp_chan.out_ref)
);
